FILE: hw/rtl/bma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants of the bipartite matching block.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_LEFT_COUNT  = 1'b0;
    localparam cfg_idx_t REG_RIGHT_COUNT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_en;
        logic start;
        logic search_init;
        logic row_cap;
        logic r_inc;
        logic take;
        logic aug_begin;
        logic enqueue;
        logic pop_cap;
        logic pop;
        logic aug_wr;
        logic aug_nx;
        logic path_inc;
        logic u_inc;
        logic finish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic cand;
        logic r_last;
        logic owned_r;
        logic queue_empty;
        logic aug_done;
        logic u_last;
    } dp_status_t;

endpackage

FILE: hw/rtl/bma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/bma_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_datapath
// Edge store, ownership and search memories, counters and result register.
// ----------------------------------------------------------------------------
module bma_datapath import bma_pkg::*; #(
    parameter int MAX_LEFT  = 64,
    parameter int MAX_RIGHT = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_idx,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic [5:0]       in_left,
    input  logic [5:0]       in_right,
    input  logic             in_present,
    input  logic             in_acc,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic             res_valid,
    output logic [CNT_W-1:0] res_data,
    input  logic             res_ready
);

    localparam int LW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
    localparam int RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
    localparam logic [MAX_RIGHT-1:0] ROW_ONE = MAX_RIGHT'(1);
    localparam logic [CNT_W-1:0] LEFT_MAX  = CNT_W'(MAX_LEFT);
    localparam logic [CNT_W-1:0] RIGHT_MAX = CNT_W'(MAX_RIGHT);

    logic [CNT_W-1:0]     left_count_reg, right_count_reg;
    logic [CNT_W-1:0]     nl_reg, nr_reg, u_reg, r_reg, head_reg, tail_reg;
    logic [CNT_W-1:0]     path_count_reg;
    logic [LW-1:0]        x_reg;
    logic [RW-1:0]        cur_reg;
    logic [MAX_RIGHT-1:0] row_reg, visited_reg, owned_reg;
    logic [MAX_LEFT-1:0]  row_valid_reg;
    logic                 ld_valid_reg;
    logic [LW-1:0]        ld_row_reg;
    logic [RW-1:0]        ld_col_reg;
    logic                 fwd_valid_reg;
    logic [LW-1:0]        fwd_row_reg;
    logic [MAX_RIGHT-1:0] fwd_data_reg;
    logic                 res_valid_reg;
    logic [CNT_W-1:0]     res_data_reg;

    logic                 in_ok;
    logic [MAX_RIGHT-1:0] adj_rdata, ld_base, ld_data;
    logic [LW-1:0]        adj_raddr;
    logic [RW-1:0]        r_idx;
    logic [LW-1:0]        owner_rdata, parent_r_rdata, queue_rdata;
    logic [RW-1:0]        parent_l_rdata;

    assign r_idx = r_reg[RW-1:0];
    assign in_ok = in_present && ({1'b0, in_left} < LEFT_MAX)
                   && ({1'b0, in_right} < RIGHT_MAX);

    // merge the new bit into the row, forwarding the write of the item before
    always_comb begin
        if (fwd_valid_reg && (fwd_row_reg == ld_row_reg)) begin
            ld_base = fwd_data_reg;
        end else if (row_valid_reg[ld_row_reg]) begin
            ld_base = adj_rdata;
        end else begin
            ld_base = '0;
        end
        ld_data = ld_base | (ROW_ONE << ld_col_reg);
    end

    assign adj_raddr = cmd.load_en ? in_left[LW-1:0] : x_reg;

    bma_ram #(.WIDTH(MAX_RIGHT), .DEPTH(MAX_LEFT)) u_adj_ram (
        .aclk(aclk), .we(ld_valid_reg), .waddr(ld_row_reg), .wdata(ld_data),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    bma_ram #(.WIDTH(LW), .DEPTH(MAX_RIGHT)) u_owner_ram (
        .aclk(aclk), .we(cmd.aug_wr), .waddr(cur_reg), .wdata(parent_r_rdata),
        .raddr(r_idx), .rdata(owner_rdata)
    );

    bma_ram #(.WIDTH(LW), .DEPTH(MAX_RIGHT)) u_parent_r_ram (
        .aclk(aclk), .we(cmd.take), .waddr(r_idx), .wdata(x_reg),
        .raddr(cur_reg), .rdata(parent_r_rdata)
    );

    bma_ram #(.WIDTH(RW), .DEPTH(MAX_LEFT)) u_parent_l_ram (
        .aclk(aclk), .we(cmd.enqueue), .waddr(owner_rdata), .wdata(r_idx),
        .raddr(parent_r_rdata), .rdata(parent_l_rdata)
    );

    bma_ram #(.WIDTH(LW), .DEPTH(MAX_LEFT)) u_queue_ram (
        .aclk(aclk), .we(cmd.enqueue), .waddr(tail_reg[LW-1:0]), .wdata(owner_rdata),
        .raddr(head_reg[LW-1:0]), .rdata(queue_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_count_reg  <= COUNT_RESET;
            right_count_reg <= COUNT_RESET;
            ld_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            row_valid_reg   <= '0;
            owned_reg       <= '0;
            visited_reg     <= '0;
            res_valid_reg   <= 1'b0;
            path_count_reg  <= '0;
            nl_reg          <= '0;
            nr_reg          <= '0;
            u_reg           <= '0;
            r_reg           <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_LEFT_COUNT:  left_count_reg  <= cfg_wdata;
                    REG_RIGHT_COUNT: right_count_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            ld_valid_reg <= in_acc && in_ok;
            if (ld_valid_reg) begin
                row_valid_reg[ld_row_reg] <= 1'b1;
                fwd_valid_reg             <= 1'b1;
            end
            if (cmd.start) begin
                nl_reg <= (left_count_reg > LEFT_MAX) ? LEFT_MAX : left_count_reg;
                nr_reg <= (right_count_reg > RIGHT_MAX) ? RIGHT_MAX : right_count_reg;
                u_reg          <= '0;
                path_count_reg <= '0;
                owned_reg      <= '0;
            end
            if (cmd.search_init) begin
                visited_reg <= '0;
                head_reg    <= '0;
                tail_reg    <= '0;
            end
            if (cmd.row_cap) begin
                r_reg <= '0;
            end
            if (cmd.r_inc || cmd.enqueue) begin
                r_reg <= r_reg + 1'b1;
            end
            if (cmd.take) begin
                visited_reg[r_idx] <= 1'b1;
            end
            if (cmd.enqueue) begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (cmd.pop) begin
                head_reg <= head_reg + 1'b1;
            end
            if (cmd.aug_wr) begin
                owned_reg[cur_reg] <= 1'b1;
            end
            if (cmd.path_inc) begin
                path_count_reg <= path_count_reg + 1'b1;
            end
            if (cmd.u_inc) begin
                u_reg <= u_reg + 1'b1;
            end
            if (cmd.finish) begin
                res_valid_reg <= 1'b1;
                row_valid_reg <= '0;
                fwd_valid_reg <= 1'b0;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ld_row_reg <= in_left[LW-1:0];
        ld_col_reg <= in_right[RW-1:0];
        if (ld_valid_reg) begin
            fwd_row_reg  <= ld_row_reg;
            fwd_data_reg <= ld_data;
        end
        if (cmd.search_init) begin
            x_reg <= u_reg[LW-1:0];
        end
        if (cmd.pop_cap) begin
            x_reg <= queue_rdata;
        end
        if (cmd.row_cap) begin
            row_reg <= row_valid_reg[x_reg] ? adj_rdata : '0;
        end
        if (cmd.aug_begin) begin
            cur_reg <= r_idx;
        end
        if (cmd.aug_nx) begin
            cur_reg <= parent_l_rdata;
        end
        if (cmd.finish) begin
            res_data_reg <= path_count_reg;
        end
    end

    always_comb begin
        status.count_zero  = (left_count_reg == '0) || (right_count_reg == '0);
        status.cand        = row_reg[r_idx] && !visited_reg[r_idx] && (r_reg < nr_reg);
        status.r_last      = (r_reg == nr_reg - 1'b1);
        status.owned_r     = owned_reg[r_idx];
        status.queue_empty = (head_reg == tail_reg);
        status.aug_done    = (CNT_W'(parent_r_rdata) == u_reg);
        status.u_last      = (u_reg == nl_reg - 1'b1);
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: hw/rtl/bma_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer for loading, breadth-first search, path flipping and answer.
// ----------------------------------------------------------------------------
module bma_ctrl import bma_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       last_acc,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_LOAD, ST_START, ST_SINIT, ST_ROW_RD, ST_ROW_CAP, ST_SCAN, ST_OWN_CHK,
        ST_POP, ST_POP_CAP, ST_AUG_RD, ST_AUG_WR, ST_AUG_NX, ST_NEXT_U, ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                cmd.load_en = 1'b1;
                if (last_acc) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = status.count_zero ? ST_FINISH : ST_SINIT;
            end
            ST_SINIT: begin
                cmd.search_init = 1'b1;
                state_next      = ST_ROW_RD;
            end
            ST_ROW_RD: begin
                state_next = ST_ROW_CAP;
            end
            ST_ROW_CAP: begin
                cmd.row_cap = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.cand) begin
                    cmd.take   = 1'b1;
                    state_next = ST_OWN_CHK;
                end else begin
                    cmd.r_inc = 1'b1;
                    if (status.r_last) begin
                        state_next = status.queue_empty ? ST_NEXT_U : ST_POP;
                    end
                end
            end
            ST_OWN_CHK: begin
                if (!status.owned_r) begin
                    cmd.aug_begin = 1'b1;
                    state_next    = ST_AUG_RD;
                end else begin
                    cmd.enqueue = 1'b1;
                    state_next  = status.r_last ? ST_POP : ST_SCAN;
                end
            end
            ST_POP: begin
                cmd.pop    = 1'b1;
                state_next = ST_POP_CAP;
            end
            ST_POP_CAP: begin
                cmd.pop_cap = 1'b1;
                state_next  = ST_ROW_RD;
            end
            ST_AUG_RD: begin
                state_next = ST_AUG_WR;
            end
            ST_AUG_WR: begin
                cmd.aug_wr = 1'b1;
                if (status.aug_done) begin
                    cmd.path_inc = 1'b1;
                    state_next   = ST_NEXT_U;
                end else begin
                    state_next = ST_AUG_NX;
                end
            end
            ST_AUG_NX: begin
                cmd.aug_nx = 1'b1;
                state_next = ST_AUG_RD;
            end
            ST_NEXT_U: begin
                cmd.u_inc  = 1'b1;
                state_next = status.u_last ? ST_FINISH : ST_SINIT;
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_LOAD;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/bipartite_matching_augment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_matching_augment
// Maximum bipartite matching by breadth-first augmenting-path search.
// ----------------------------------------------------------------------------
// Edges load one item per cycle while loading; an item with tuser low stores
// nothing. The item with tlast set closes the graph and starts the search,
// which runs with the input stalled. For each left vertex one search runs;
// for each left vertex taken from the search queue the adjacency row is read
// and scanned one right vertex per cycle, pausing at each new right vertex
// reached for an ownership check, and ownerships are flipped edge by edge
// along a path once one is found. The answer then stands on the result port
// until taken; edges of the next graph may load meanwhile, and its closing
// item waits for that take.
// ----------------------------------------------------------------------------
module bipartite_matching_augment import bma_pkg::*; #(
    parameter int MAX_LEFT  = 64,
    parameter int MAX_RIGHT = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,  // left_vertex[5:0], right_vertex[11:6]
    input  logic             s_axis_tuser,  // edge_present
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // matching_size[6:0]
    input  logic             cfg_we,
    input  cfg_idx_t         cfg_idx,
    input  logic [CNT_W-1:0] cfg_wdata
);

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic             in_acc;
    logic [CNT_W-1:0] res_data;

    // closing item waits while the previous answer is still held
    assign s_axis_tready = cmd.load_en && !(m_axis_tvalid && s_axis_tlast);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = {1'b0, res_data};

    bma_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .last_acc(in_acc && s_axis_tlast),
        .status(status), .cmd(cmd)
    );

    bma_datapath #(.MAX_LEFT(MAX_LEFT), .MAX_RIGHT(MAX_RIGHT)) u_datapath (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .in_left(s_axis_tdata[5:0]), .in_right(s_axis_tdata[11:6]),
        .in_present(s_axis_tuser), .in_acc(in_acc),
        .cmd(cmd), .status(status),
        .res_valid(m_axis_tvalid), .res_data(res_data), .res_ready(m_axis_tready)
    );

    a_no_close_over_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |-> !(s_axis_tlast && m_axis_tvalid))
        else $error("closing item accepted while answer pending");

    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res_data <= CNT_W'(MAX_LEFT)) && (res_data <= CNT_W'(MAX_RIGHT)))
        else $error("matching size above vertex bound");

    a_closing_starts_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after closing item");

endmodule

FILE: bench/bipartite_matching_augment_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bipartite_matching_augment_tb
// Checks the maximum matching size reported for streamed bipartite graphs.
// ----------------------------------------------------------------------------
// Graphs are streamed edge by edge. A local augmenting-path solver predicts
// each answer, and every reported size is compared with the oldest
// prediction. The run covers directed corner graphs and random graphs under
// several count settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module bipartite_matching_augment_tb;
    import bma_pkg::*;

    localparam int  MAXV      = 64;
    localparam int  CYC_LIMIT = 20000000;
    localparam byte UNOWNED   = 8'd127;

    typedef struct packed {
        logic [5:0] lv;
        logic [5:0] rv;
        logic       present;
        logic       last;
    } edge_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    cfg_idx_t cfg_idx = REG_LEFT_COUNT;
    logic [CNT_W-1:0] cfg_wdata = '0;

    bipartite_matching_augment DUT (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor state
    logic [63:0] adj_rows [MAXV];
    int unsigned left_cnt = 64;
    int unsigned right_cnt = 64;

    edge_item_t  pending_items [$];
    logic [6:0]  expected_sizes [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int sizes_seen = 0;
    int graphs_sent = 0;
    longint cycles = 0;

    // one breadth-first augmenting search per free left vertex
    function automatic logic [6:0] max_matching();
        int nl, nr, pathc, head, tail, x, own, cur, p;
        byte owner [MAXV];
        bit  seen [2*MAXV];
        int  parent [2*MAXV];
        int  bfs [MAXV+1];
        bit  found;
        nl = (left_cnt > MAXV) ? MAXV : left_cnt;
        nr = (right_cnt > MAXV) ? MAXV : right_cnt;
        pathc = 0;
        foreach (owner[i]) owner[i] = UNOWNED;
        if (nl == 0 || nr == 0) return 7'd0;
        for (int u = 0; u < nl; u++) begin
            foreach (seen[i]) begin
                seen[i] = 0;
                parent[i] = 0;
            end
            head = 0;
            tail = 0;
            found = 0;
            seen[u] = 1;
            bfs[tail++] = u;
            while (head < tail && !found) begin
                x = bfs[head++];
                for (int r = 0; r < nr && !found; r++) begin
                    if (adj_rows[x][r] && !seen[MAXV+r]) begin
                        seen[MAXV+r] = 1;
                        parent[MAXV+r] = x;
                        own = owner[r];
                        if (own == UNOWNED) begin
                            cur = r;
                            forever begin
                                p = parent[MAXV+cur];
                                owner[cur] = byte'(p);
                                if (p == u) break;
                                cur = (parent[p] - MAXV) & 63;
                            end
                            pathc++;
                            found = 1;
                        end else if (own < nl && !seen[own] && tail <= MAXV) begin
                            seen[own] = 1;
                            parent[own] = MAXV + r;
                            bfs[tail++] = own;
                        end
                    end
                end
            end
        end
        return 7'(pathc);
    endfunction

    task automatic add_edge(input int l, input int r, input bit pres, input bit lst);
        edge_item_t it;
        it.lv = 6'(l);
        it.rv = 6'(r);
        it.present = pres;
        it.last = lst;
        pending_items = {pending_items, it};
    endtask

    task automatic random_graph(input int n_edges, input int lmax, input int rmax);
        for (int i = 0; i < n_edges; i++)
            add_edge($urandom_range(lmax, 0), $urandom_range(rmax, 0),
                     $urandom_range(9, 0) != 0, 1'b0);
        add_edge($urandom_range(63, 0), $urandom_range(63, 0), $urandom_range(1, 0), 1'b1);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_sizes.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_counts(input int l, input int r);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_LEFT_COUNT;
        cfg_wdata <= 7'(l);
        @(posedge aclk);
        cfg_idx   <= REG_RIGHT_COUNT;
        cfg_wdata <= 7'(r);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        left_cnt  = l;
        right_cnt = r;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    edge_item_t it;
                    it = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, it.rv, it.lv};
                    s_axis_tuser  <= it.present;
                    s_axis_tlast  <= it.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // predictor updates on accepted items, checker on accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser)
                    adj_rows[s_axis_tdata[5:0]][s_axis_tdata[11:6]] = 1'b1;
                if (s_axis_tlast) begin
                    expected_sizes = {expected_sizes, max_matching()};
                    foreach (adj_rows[i]) adj_rows[i] = '0;
                    graphs_sent++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sizes_seen++;
                if (expected_sizes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: expected none got %0d",
                                 m_axis_tdata[6:0]);
                end else begin
                    logic [6:0] want;
                    want = expected_sizes.pop_front();
                    if (m_axis_tdata[6:0] !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("size mismatch: expected %0d got %0d", want,
                                     m_axis_tdata[6:0]);
                    end
                end
            end
            if (cycles > CYC_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("bipartite_matching_augment: mismatch");
                $finish;
            end
        end
    end

    initial begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 6;
        recv_idle_pct = 56;

        // directed: corners at reset counts
        add_edge(0, 0, 1, 1);
        add_edge(63, 63, 1, 0);
        add_edge(63, 63, 1, 0);
        add_edge(42, 21, 1, 0);
        add_edge(21, 42, 0, 1);
        add_edge(0, 0, 0, 1);
        // path that needs rerouting: 0-{0,1}, 1-{0}
        add_edge(0, 0, 1, 0);
        add_edge(0, 1, 1, 0);
        add_edge(1, 0, 1, 1);
        // chain of edges i-i and (i+1)-i over six left vertices
        for (int i = 0; i < 6; i++) add_edge(i, i, 1, 0);
        for (int i = 0; i < 5; i++) add_edge(i + 1, i, 1, 0);
        add_edge(0, 5, 0, 1);
        drain();

        // out of count edges ignored
        write_counts(4, 3);
        add_edge(3, 2, 1, 0);
        add_edge(5, 1, 1, 0);
        add_edge(1, 5, 1, 0);
        add_edge(0, 0, 1, 1);
        drain();

        write_counts(0, 64);
        add_edge(0, 0, 1, 1);
        drain();
        write_counts(64, 0);
        add_edge(0, 0, 1, 1);
        drain();
        write_counts(127, 127);
        for (int i = 0; i < 64; i++) add_edge(i, 63 - i, 1, 0);
        add_edge(0, 0, 0, 1);
        drain();

        // random graphs: mostly small counts, a few large
        write_counts(8, 8);
        for (int g = 0; g < 50; g++) random_graph($urandom_range(12, 1), 9, 9);
        drain();
        // pause until all answers are in, then carry on
        send_idle_pct = 56;
        recv_idle_pct = 6;
        write_counts(12, 5);
        for (int g = 0; g < 40; g++) random_graph($urandom_range(14, 1), 13, 6);
        drain();
        write_counts(1, 1);
        for (int g = 0; g < 15; g++) random_graph($urandom_range(3, 1), 1, 1);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_counts(16, 16);
        for (int g = 0; g < 25; g++) random_graph($urandom_range(20, 1), 17, 17);
        drain();
        write_counts(64, 64);
        for (int g = 0; g < 3; g++) random_graph(100, 63, 63);
        drain();

        $display("%0d graphs streamed, %0d sizes checked, counts from 0 to 127 applied",
                 graphs_sent, sizes_seen);
        if (mismatches == 0 && expected_sizes.size() == 0)
            $display("bipartite_matching_augment: match");
        else
            $display("bipartite_matching_augment: mismatch");
        $finish;
    end
endmodule
